[rtl/wieb_pkg.sv]
// Shared types, codes and constant tables of the WLAN information element builder.
package wieb_pkg;

   // Default for the SSID saturation limit
   localparam int SSID_MAX_BYTES_DEF = 32;

   // Input command codes
   localparam logic CMD_DESCRIPTOR = 1'b0;
   localparam logic CMD_SSID_BYTE  = 1'b1;

   // Element IDs
   localparam logic [7:0] ID_SSID      = 8'd0;
   localparam logic [7:0] ID_RATES     = 8'd1;
   localparam logic [7:0] ID_DS        = 8'd3;
   localparam logic [7:0] ID_RSN       = 8'd48;
   localparam logic [7:0] ID_EXT_RATES = 8'd50;
   localparam logic [7:0] ID_VENDOR    = 8'd221;

   // Cipher suite types
   localparam logic [7:0] SUITE_CCMP    = 8'd4;
   localparam logic [7:0] SUITE_TKIP    = 8'd2;
   localparam logic [7:0] SUITE_GCMP    = 8'd8;
   localparam logic [7:0] SUITE_GCMP256 = 8'd9;

   // AKM suite types
   localparam logic [7:0] AKM_EAP = 8'd1;
   localparam logic [7:0] AKM_PSK = 8'd2;
   localparam logic [7:0] AKM_SAE = 8'd8;
   localparam logic [7:0] AKM_OWE = 8'd18;

   // WPA vendor OUI type
   localparam logic [7:0] WPA_OUI_TYPE = 8'd1;

   // Byte counts of one result
   localparam logic [1:0] BYTES_ONE = 2'd1;
   localparam logic [1:0] BYTES_TWO = 2'd2;

   // Segments of the element tail, walked in this order
   typedef enum logic [2:0] {
      SEG_RATES,
      SEG_EXT,
      SEG_DS,
      SEG_SEC_HEAD,
      SEG_PW,
      SEG_MID,
      SEG_AKM,
      SEG_END
   } seg_type;

   // What the datapath puts into the output register
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_HEADER,
      EMIT_ECHO,
      EMIT_TAIL
   } emit_type;

   typedef struct packed {
      logic     load;
      emit_type emit;
      seg_type  seg;
   } wieb_cmd_type;

   typedef struct packed {
      logic out_free;
      logic left_zero;
      logic left_one;
      logic tail_take;
      logic seg_last;
      logic tail_last;
      logic ext_present;
      logic pw_empty;
   } wieb_status_type;

   // OUI byte k of the RSN or WPA suite selector
   function automatic logic [7:0] oui_byte(input logic rsn, input logic [1:0] k);
      logic [7:0] b;
      unique case (k)
         2'd0:    b = 8'h00;
         2'd1:    b = rsn ? 8'h0f : 8'h50;
         2'd2:    b = rsn ? 8'hac : 8'hf2;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Combined rate list: CCK rates, then OFDM rates
   function automatic logic [7:0] rate_entry(input logic [3:0] k);
      logic [7:0] b;
      unique case (k)
         4'd0:    b = 8'h82;
         4'd1:    b = 8'h84;
         4'd2:    b = 8'h8b;
         4'd3:    b = 8'h96;
         4'd4:    b = 8'h0c;
         4'd5:    b = 8'h12;
         4'd6:    b = 8'h18;
         4'd7:    b = 8'h24;
         4'd8:    b = 8'h30;
         4'd9:    b = 8'h48;
         4'd10:   b = 8'h60;
         4'd11:   b = 8'h6c;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Cipher suite type of mask bit position
   function automatic logic [7:0] cipher_type(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0:    b = SUITE_CCMP;
         2'd1:    b = SUITE_TKIP;
         2'd2:    b = SUITE_GCMP;
         default: b = SUITE_GCMP256;
      endcase
      return b;
   endfunction

   // AKM suite type of reordered mask bit position (EAP, PSK, SAE, OWE)
   function automatic logic [7:0] akm_type(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0:    b = AKM_EAP;
         2'd1:    b = AKM_PSK;
         2'd2:    b = AKM_SAE;
         default: b = AKM_OWE;
      endcase
      return b;
   endfunction

   // Position of the j-th set bit of a 4-bit mask
   function automatic logic [1:0] nth_set(input logic [3:0] mask, input logic [1:0] j);
      logic [2:0] cnt;
      logic [1:0] pos;
      cnt = 3'd0;
      pos = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (cnt == {1'b0, j}) begin
               pos = 2'(i);
            end
            cnt = cnt + 3'd1;
         end
      end
      return pos;
   endfunction

   // Number of set bits in a 4-bit mask
   function automatic logic [2:0] count4(input logic [3:0] mask);
      return 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
   endfunction

endpackage

[rtl/wieb_ctrl.sv]
// Controller state machine: input handshake, result sequence and tail segment walk.
module wieb_ctrl import wieb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_command,
   output logic            req_stall,
   input  wieb_status_type status,
   output wieb_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_HEADER = 4'b0010,
      ST_ECHO   = 4'b0100,
      ST_TAIL   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   seg_type   seg_ff, seg_in;
   logic      accept;

   // Take an item only while idle
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // Next state, segment and datapath command
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      cmd.load = accept;
      cmd.emit = EMIT_NONE;
      cmd.seg  = seg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_DESCRIPTOR) begin
                  state_in = ST_HEADER;
               end else if (!status.left_zero) begin
                  state_in = ST_ECHO;
               end
            end
         end
         ST_HEADER: begin
            cmd.emit = EMIT_HEADER;
            if (status.out_free) begin
               seg_in   = SEG_RATES;
               state_in = status.left_zero ? ST_TAIL : ST_IDLE;
            end
         end
         ST_ECHO: begin
            cmd.emit = EMIT_ECHO;
            if (status.out_free) begin
               seg_in   = SEG_RATES;
               state_in = status.left_one ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            cmd.emit = EMIT_TAIL;
            if (status.tail_take && status.seg_last) begin
               if (status.tail_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // Advance to the next segment, skip empty ones
                  unique case (seg_ff)
                     SEG_RATES:    seg_in = status.ext_present ? SEG_EXT : SEG_DS;
                     SEG_EXT:      seg_in = SEG_DS;
                     SEG_DS:       seg_in = SEG_SEC_HEAD;
                     SEG_SEC_HEAD: seg_in = status.pw_empty ? SEG_MID : SEG_PW;
                     SEG_PW:       seg_in = SEG_MID;
                     SEG_MID:      seg_in = SEG_AKM;
                     SEG_AKM:      seg_in = SEG_END;
                     SEG_END:      seg_in = SEG_RATES;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff   <= SEG_RATES;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
      end
   end

endmodule

[rtl/wieb_datapath.sv]
// Datapath: held network fields, SSID counter, tail byte generator and output packer.
module wieb_datapath import wieb_pkg::*; #(
   parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_command,
   input  logic [5:0]      req_ssid_length,
   input  logic [7:0]      req_channel_number,
   input  logic [1:0]      req_phy_flags,
   input  logic [4:0]      req_akm_flags,
   input  logic [3:0]      req_pairwise_ciphers,
   input  logic [3:0]      req_group_ciphers,
   input  logic [7:0]      req_ssid_byte,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic [7:0]      rsp_first_byte,
   output logic [7:0]      rsp_second_byte,
   output logic [1:0]      rsp_byte_count,
   output logic            rsp_last,
   input  wieb_cmd_type    cmd,
   output wieb_status_type status
);

   localparam int         LEFT_W  = $clog2(SSID_MAX_BYTES + 1);
   localparam logic [5:0] MAX_LEN = 6'(SSID_MAX_BYTES);

   // Held network fields and SSID progress
   logic [7:0]        held_channel_ff;
   logic [1:0]        held_phy_ff;
   logic [4:0]        held_akm_ff;
   logic [3:0]        held_pairwise_ff;
   logic [3:0]        held_group_ff;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [7:0]        ssid_byte_ff;

   // Tail sequencing and packing
   logic [3:0]        idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_first_ff, rsp_first_in;
   logic [7:0]        rsp_second_ff, rsp_second_in;
   logic [1:0]        rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [LEFT_W-1:0] len_sat;
   logic              out_free;
   logic              cck, ofdm, ext;
   logic [3:0]        pw, grp, pw_mask, akm_mask;
   logic [7:0]        gtype;
   logic              wpa, rsn, mfpc, mfpr;
   logic [2:0]        pcnt, acnt;
   logic [7:0]        sec_len;
   logic [4:0]        seg_len;
   logic              seg_last, tail_last, take;
   logic [7:0]        tb;
   logic [1:0]        k, j;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign len_sat  = (req_ssid_length > MAX_LEN) ? LEFT_W'(SSID_MAX_BYTES)
                                                 : LEFT_W'(req_ssid_length);

   // Decode the held descriptor
   assign cck      = held_phy_ff[0] | ~held_phy_ff[1];
   assign ofdm     = held_phy_ff[1];
   assign ext      = cck & ofdm;
   assign pw       = (held_pairwise_ff == 4'd0) ? 4'd1 : held_pairwise_ff;
   assign grp      = (held_group_ff == 4'd0) ? pw : held_group_ff;
   assign gtype    = grp[1] ? SUITE_TKIP : grp[2] ? SUITE_GCMP :
                     grp[3] ? SUITE_GCMP256 : SUITE_CCMP;
   assign wpa      = held_akm_ff[0];
   assign rsn      = ~held_akm_ff[0] & (|held_akm_ff[4:1]);
   assign pw_mask  = wpa ? {2'b00, pw[1:0]} : pw;
   assign akm_mask = {held_akm_ff[4], held_akm_ff[2], held_akm_ff[1], held_akm_ff[3]};
   assign pcnt     = count4(pw_mask);
   assign acnt     = count4(akm_mask);
   assign mfpc     = held_akm_ff[4] | held_akm_ff[2];
   assign mfpr     = mfpc & ~(held_akm_ff[3] | held_akm_ff[1]);
   assign sec_len  = wpa ? (8'd18 + {3'b000, pcnt, 2'b00})
                         : (8'd12 + {3'b000, pcnt, 2'b00} + {3'b000, acnt, 2'b00});
   assign k        = idx_ff[1:0];
   assign j        = idx_ff[3:2];

   // Length of the current segment
   always_comb begin
      unique case (cmd.seg)
         SEG_RATES:    seg_len = ofdm ? 5'd10 : 5'd6;
         SEG_EXT:      seg_len = 5'd6;
         SEG_DS:       seg_len = 5'd3;
         SEG_SEC_HEAD: seg_len = wpa ? 5'd14 : 5'd10;
         SEG_PW:       seg_len = {pcnt, 2'b00};
         SEG_MID:      seg_len = wpa ? 5'd6 : 5'd2;
         SEG_AKM:      seg_len = {acnt, 2'b00};
         SEG_END:      seg_len = 5'd2;
      endcase
   end

   // Flag the final byte of a segment and of the whole tail
   assign seg_last  = ({1'b0, idx_ff} == (seg_len - 5'd1));
   assign tail_last = seg_last & (((cmd.seg == SEG_DS) & ~wpa & ~rsn) |
                                  ((cmd.seg == SEG_MID) & wpa) |
                                  (cmd.seg == SEG_END));

   // Generate the tail byte at the current segment and index
   always_comb begin
      tb = 8'h00;
      unique case (cmd.seg)
         SEG_RATES: begin
            priority case (idx_ff)
               4'd0:    tb = ID_RATES;
               4'd1:    tb = ofdm ? 8'd8 : 8'd4;
               default: tb = rate_entry(cck ? (idx_ff - 4'd2) : (idx_ff + 4'd2));
            endcase
         end
         SEG_EXT: begin
            priority case (idx_ff)
               4'd0:    tb = ID_EXT_RATES;
               4'd1:    tb = 8'd4;
               default: tb = rate_entry(idx_ff + 4'd6);
            endcase
         end
         SEG_DS: begin
            priority case (idx_ff)
               4'd0:    tb = ID_DS;
               4'd1:    tb = 8'd1;
               default: tb = held_channel_ff;
            endcase
         end
         SEG_SEC_HEAD: begin
            if (wpa) begin
               priority case (idx_ff)
                  4'd0:    tb = ID_VENDOR;
                  4'd1:    tb = sec_len;
                  4'd2:    tb = oui_byte(1'b0, 2'd0);
                  4'd3:    tb = oui_byte(1'b0, 2'd1);
                  4'd4:    tb = oui_byte(1'b0, 2'd2);
                  4'd5:    tb = WPA_OUI_TYPE;
                  4'd6:    tb = 8'd1;
                  4'd7:    tb = 8'd0;
                  4'd8:    tb = oui_byte(1'b0, 2'd0);
                  4'd9:    tb = oui_byte(1'b0, 2'd1);
                  4'd10:   tb = oui_byte(1'b0, 2'd2);
                  4'd11:   tb = gtype;
                  4'd12:   tb = {5'd0, pcnt};
                  default: tb = 8'd0;
               endcase
            end else begin
               priority case (idx_ff)
                  4'd0:    tb = ID_RSN;
                  4'd1:    tb = sec_len;
                  4'd2:    tb = 8'd1;
                  4'd3:    tb = 8'd0;
                  4'd4:    tb = oui_byte(1'b1, 2'd0);
                  4'd5:    tb = oui_byte(1'b1, 2'd1);
                  4'd6:    tb = oui_byte(1'b1, 2'd2);
                  4'd7:    tb = gtype;
                  4'd8:    tb = {5'd0, pcnt};
                  default: tb = 8'd0;
               endcase
            end
         end
         SEG_PW: begin
            tb = (k == 2'd3) ? cipher_type(nth_set(pw_mask, j)) : oui_byte(rsn, k);
         end
         SEG_MID: begin
            if (wpa) begin
               priority case (idx_ff)
                  4'd0:    tb = 8'd1;
                  4'd1:    tb = 8'd0;
                  4'd2:    tb = oui_byte(1'b0, 2'd0);
                  4'd3:    tb = oui_byte(1'b0, 2'd1);
                  4'd4:    tb = oui_byte(1'b0, 2'd2);
                  default: tb = held_akm_ff[3] ? AKM_EAP : AKM_PSK;
               endcase
            end else begin
               tb = (idx_ff == 4'd0) ? {5'd0, acnt} : 8'd0;
            end
         end
         SEG_AKM: begin
            tb = (k == 2'd3) ? akm_type(nth_set(akm_mask, j)) : oui_byte(1'b1, k);
         end
         SEG_END: begin
            tb = (idx_ff == 4'd0) ? {mfpc, mfpr, 6'd0} : 8'd0;
         end
      endcase
   end

   // A tail byte moves on unless it must go out and the output is blocked
   assign take = (cmd.emit == EMIT_TAIL) & ((~pend_ff & ~tail_last) | out_free);

   // Pack bytes into results and advance counters
   always_comb begin
      left_in       = left_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_byte_in  = pend_byte_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load && (req_command == CMD_DESCRIPTOR)) begin
         left_in = len_sat;
      end
      unique case (cmd.emit)
         EMIT_NONE: begin
         end
         EMIT_HEADER: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = ID_SSID;
               rsp_second_in = 8'(left_ff);
               rsp_count_in  = BYTES_TWO;
               rsp_last_in   = 1'b0;
            end
         end
         EMIT_ECHO: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = ssid_byte_ff;
               rsp_second_in = 8'd0;
               rsp_count_in  = BYTES_ONE;
               rsp_last_in   = 1'b0;
               left_in       = left_ff - LEFT_W'(1);
            end
         end
         EMIT_TAIL: begin
            if (take) begin
               idx_in = seg_last ? 4'd0 : (idx_ff + 4'd1);
               if (pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_first_in  = pend_byte_ff;
                  rsp_second_in = tb;
                  rsp_count_in  = BYTES_TWO;
                  rsp_last_in   = tail_last;
                  pend_in       = 1'b0;
               end else if (tail_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_first_in  = tb;
                  rsp_second_in = 8'd0;
                  rsp_count_in  = BYTES_ONE;
                  rsp_last_in   = 1'b1;
               end else begin
                  pend_in      = 1'b1;
                  pend_byte_in = tb;
               end
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_channel_ff  <= 8'd0;
         held_phy_ff      <= 2'd0;
         held_akm_ff      <= 5'd0;
         held_pairwise_ff <= 4'd0;
         held_group_ff    <= 4'd0;
         left_ff          <= '0;
         idx_ff           <= 4'd0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (cmd.load && (req_command == CMD_DESCRIPTOR)) begin
            held_channel_ff  <= req_channel_number;
            held_phy_ff      <= req_phy_flags;
            held_akm_ff      <= req_akm_flags;
            held_pairwise_ff <= req_pairwise_ciphers;
            held_group_ff    <= req_group_ciphers;
         end
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load && (req_command == CMD_SSID_BYTE)) begin
         ssid_byte_ff <= req_ssid_byte;
      end
      pend_byte_ff  <= pend_byte_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_byte  = rsp_first_ff;
   assign rsp_second_byte = rsp_second_ff;
   assign rsp_byte_count  = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   assign status.out_free    = out_free;
   assign status.left_zero   = (left_ff == '0);
   assign status.left_one    = (left_ff == LEFT_W'(1));
   assign status.tail_take   = take;
   assign status.seg_last    = seg_last;
   assign status.tail_last   = tail_last;
   assign status.ext_present = ext;
   assign status.pw_empty    = (pcnt == 3'd0);

endmodule

[rtl/wlan_info_element_builder.sv]
// Top level of the WLAN information element builder: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  command, length, channel, PHY, AKM, ciphers, byte
//   rsp_     out        rsp_valid / rsp_stall  first byte, second byte, byte count, last
//
// A descriptor is accepted and then emits the SSID header; each SSID byte is accepted and then echoed,
// a stray SSID byte is only accepted.
// The element tail follows the last SSID byte; the tail byte sequencer produces one byte per cycle
// while rsp_stall does not hold it, and packs two per result.
// Synchronous reset clears the held network fields, the SSID count and the output valid flag.
// rsp_stall holds the output register and the tail sequencer; items are taken only when idle.
module wlan_info_element_builder import wieb_pkg::*; #(
   parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [5:0] req_ssid_length,
   input  logic [7:0] req_channel_number,
   input  logic [1:0] req_phy_flags,
   input  logic [4:0] req_akm_flags,
   input  logic [3:0] req_pairwise_ciphers,
   input  logic [3:0] req_group_ciphers,
   input  logic [7:0] req_ssid_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_first_byte,
   output logic [7:0] rsp_second_byte,
   output logic [1:0] rsp_byte_count,
   output logic       rsp_last
);

   wieb_cmd_type    cmd;
   wieb_status_type status;

   // Sequence items and tail segments
   wieb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Hold fields, build bytes and drive results
   wieb_datapath #(
      .SSID_MAX_BYTES (SSID_MAX_BYTES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_command),
      .req_ssid_length      (req_ssid_length),
      .req_channel_number   (req_channel_number),
      .req_phy_flags        (req_phy_flags),
      .req_akm_flags        (req_akm_flags),
      .req_pairwise_ciphers (req_pairwise_ciphers),
      .req_group_ciphers    (req_group_ciphers),
      .req_ssid_byte        (req_ssid_byte),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_first_byte       (rsp_first_byte),
      .rsp_second_byte      (rsp_second_byte),
      .rsp_byte_count       (rsp_byte_count),
      .rsp_last             (rsp_last),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

[dv/wlan_info_element_builder_checker.sv]
`timescale 1ns / 1ps
// Checker for the WLAN information element builder: watches both channels, predicts and compares.
module wlan_info_element_builder_checker import wieb_pkg::*; #(
   parameter int SSID_MAX_BYTES = SSID_MAX_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_command,
   input  logic [5:0] req_ssid_length,
   input  logic [7:0] req_channel_number,
   input  logic [1:0] req_phy_flags,
   input  logic [4:0] req_akm_flags,
   input  logic [3:0] req_pairwise_ciphers,
   input  logic [3:0] req_group_ciphers,
   input  logic [7:0] req_ssid_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_first_byte,
   input  logic [7:0] rsp_second_byte,
   input  logic [1:0] rsp_byte_count,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         results_pending
);

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
      logic       last;
   } ie_result_type;

   localparam logic [23:0] OUI_RSN         = 24'h000fac;
   localparam logic [23:0] OUI_WPA         = 24'h0050f2;
   localparam logic [31:0] CCK_RATE_BYTES  = 32'h82848b96;
   localparam logic [63:0] OFDM_RATE_BYTES = 64'h0c1218243048606c;
   localparam logic [7:0]  RSN_VERSION     = 8'd1;
   localparam logic [7:0]  WPA_VERSION     = 8'd1;

   // Network fields latched from the last descriptor
   logic [7:0] held_channel;
   logic [1:0] held_phy;
   logic [4:0] held_akm;
   logic [3:0] held_pairwise;
   logic [3:0] held_group;
   logic [5:0] ssid_left;

   ie_result_type element_results[$];
   logic [7:0]    tail_bytes[$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] element check: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void add_suite(input logic [23:0] oui, input logic [7:0] suite);
      tail_bytes.push_back(oui[23:16]);
      tail_bytes.push_back(oui[15:8]);
      tail_bytes.push_back(oui[7:0]);
      tail_bytes.push_back(suite);
   endfunction

   // Group cipher priority: TKIP, GCMP, GCMP256, else CCMP
   function automatic logic [7:0] group_suite(input logic [3:0] mask);
      if (mask[1]) return SUITE_TKIP;
      if (mask[2]) return SUITE_GCMP;
      if (mask[3]) return SUITE_GCMP256;
      return SUITE_CCMP;
   endfunction

   // Append a counted cipher suite list, count patched in afterwards
   function automatic void add_cipher_list(input logic [23:0] oui, input logic [3:0] mask);
      int         cnt_pos;
      logic [7:0] cnt;
      cnt_pos = tail_bytes.size();
      cnt = 8'd0;
      tail_bytes.push_back(8'd0);
      tail_bytes.push_back(8'd0);
      if (mask[0]) begin add_suite(oui, SUITE_CCMP);    cnt++; end
      if (mask[1]) begin add_suite(oui, SUITE_TKIP);    cnt++; end
      if (mask[2]) begin add_suite(oui, SUITE_GCMP);    cnt++; end
      if (mask[3]) begin add_suite(oui, SUITE_GCMP256); cnt++; end
      tail_bytes[cnt_pos] = cnt;
   endfunction

   // Build the element tail from the held network and queue it two bytes per result
   function automatic void queue_tail();
      logic [3:0]    pw;
      logic [3:0]    grp;
      logic [7:0]    rates[$];
      int            first_cnt;
      int            len_pos;
      int            cnt_pos;
      logic [7:0]    akm_cnt;
      logic          mfp_capable;
      logic          mfp_required;
      int            i;
      ie_result_type r;

      tail_bytes.delete();
      pw  = (held_pairwise != 4'd0) ? held_pairwise : 4'b0001;
      grp = (held_group != 4'd0) ? held_group : pw;

      // rates: CCK when 11b is set or nothing is set, then OFDM
      if (held_phy[0] || held_phy == 2'd0) begin
         for (i = 0; i < 4; i++) rates.push_back(CCK_RATE_BYTES[31 - 8 * i -: 8]);
      end
      if (held_phy[1]) begin
         for (i = 0; i < 8; i++) rates.push_back(OFDM_RATE_BYTES[63 - 8 * i -: 8]);
      end
      first_cnt = (rates.size() < 8) ? rates.size() : 8;
      tail_bytes.push_back(ID_RATES);
      tail_bytes.push_back(8'(first_cnt));
      for (i = 0; i < first_cnt; i++) tail_bytes.push_back(rates[i]);
      if (rates.size() > first_cnt) begin
         tail_bytes.push_back(ID_EXT_RATES);
         tail_bytes.push_back(8'(rates.size() - first_cnt));
         for (i = first_cnt; i < rates.size(); i++) tail_bytes.push_back(rates[i]);
      end

      tail_bytes.push_back(ID_DS);
      tail_bytes.push_back(8'd1);
      tail_bytes.push_back(held_channel);

      if (held_akm[0]) begin
         // WPA vendor element: only CCMP and TKIP listed as pairwise
         tail_bytes.push_back(ID_VENDOR);
         len_pos = tail_bytes.size();
         tail_bytes.push_back(8'd0);
         add_suite(OUI_WPA, WPA_OUI_TYPE);
         tail_bytes.push_back(WPA_VERSION);
         tail_bytes.push_back(8'd0);
         add_suite(OUI_WPA, group_suite(grp));
         add_cipher_list(OUI_WPA, {2'b00, pw[1:0]});
         tail_bytes.push_back(8'd1);
         tail_bytes.push_back(8'd0);
         add_suite(OUI_WPA, held_akm[3] ? AKM_EAP : AKM_PSK);
         tail_bytes[len_pos] = 8'(tail_bytes.size() - len_pos - 1);
      end else if (held_akm[4:1] != 4'd0) begin
         // RSN element with AKM list in EAP, PSK, SAE, OWE order
         mfp_capable  = held_akm[2] || held_akm[4];
         mfp_required = mfp_capable && !(held_akm[1] || held_akm[3]);
         tail_bytes.push_back(ID_RSN);
         len_pos = tail_bytes.size();
         tail_bytes.push_back(8'd0);
         tail_bytes.push_back(RSN_VERSION);
         tail_bytes.push_back(8'd0);
         add_suite(OUI_RSN, group_suite(grp));
         add_cipher_list(OUI_RSN, pw);
         cnt_pos = tail_bytes.size();
         akm_cnt = 8'd0;
         tail_bytes.push_back(8'd0);
         tail_bytes.push_back(8'd0);
         if (held_akm[3]) begin add_suite(OUI_RSN, AKM_EAP); akm_cnt++; end
         if (held_akm[1]) begin add_suite(OUI_RSN, AKM_PSK); akm_cnt++; end
         if (held_akm[2]) begin add_suite(OUI_RSN, AKM_SAE); akm_cnt++; end
         if (held_akm[4]) begin add_suite(OUI_RSN, AKM_OWE); akm_cnt++; end
         tail_bytes[cnt_pos] = akm_cnt;
         tail_bytes.push_back({mfp_capable, mfp_required, 6'd0});
         tail_bytes.push_back(8'd0);
         tail_bytes[len_pos] = 8'(tail_bytes.size() - len_pos - 1);
      end

      // pack two bytes per result, odd byte alone at the end
      for (i = 0; i < tail_bytes.size(); i += 2) begin
         if (i + 1 < tail_bytes.size()) begin
            r = '{tail_bytes[i], tail_bytes[i + 1], BYTES_TWO, (i + 2 >= tail_bytes.size())};
         end else begin
            r = '{tail_bytes[i], 8'd0, BYTES_ONE, 1'b1};
         end
         element_results.push_back(r);
      end
   endfunction

   // Predict on accepted items, compare accepted results
   always @(posedge clock) begin
      ie_result_type want;
      int            len;
      if (reset) begin
         held_channel  = '0;
         held_phy      = '0;
         held_akm      = '0;
         held_pairwise = '0;
         held_group    = '0;
         ssid_left     = '0;
         element_results.delete();
         results_pending <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_command == CMD_DESCRIPTOR) begin
               len = (req_ssid_length > SSID_MAX_BYTES) ? SSID_MAX_BYTES : req_ssid_length;
               held_channel  = req_channel_number;
               held_phy      = req_phy_flags;
               held_akm      = req_akm_flags;
               held_pairwise = req_pairwise_ciphers;
               held_group    = req_group_ciphers;
               ssid_left     = 6'(len);
               element_results.push_back('{ID_SSID, 8'(len), BYTES_TWO, 1'b0});
               if (len == 0) queue_tail();
            end else if (ssid_left != 6'd0) begin
               // drop stray bytes, echo pending ones
               element_results.push_back('{req_ssid_byte, 8'd0, BYTES_ONE, 1'b0});
               ssid_left = ssid_left - 6'd1;
               if (ssid_left == 6'd0) queue_tail();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (element_results.size() == 0) begin
               report_mismatch($sformatf("unpredicted result %02h %02h count %0d last %0b",
                  rsp_first_byte, rsp_second_byte, rsp_byte_count, rsp_last));
            end else begin
               want = element_results.pop_front();
               if (rsp_first_byte !== want.first_byte)
                  report_mismatch($sformatf("first_byte %02h, predicted %02h",
                     rsp_first_byte, want.first_byte));
               if (rsp_second_byte !== want.second_byte)
                  report_mismatch($sformatf("second_byte %02h, predicted %02h",
                     rsp_second_byte, want.second_byte));
               if (rsp_byte_count !== want.byte_count)
                  report_mismatch($sformatf("byte_count %0d, predicted %0d",
                     rsp_byte_count, want.byte_count));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, predicted %0b", rsp_last, want.last));
            end
         end
         results_pending <= element_results.size();
      end
   end

endmodule

[dv/wlan_info_element_builder_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the WLAN information element builder: stimulus, receiver stalls, verdict.
module wlan_info_element_builder_tb;
   import wieb_pkg::*;

   localparam int SSID_LIMIT     = SSID_MAX_BYTES_DEF;
   localparam int RANDOM_ITEMS   = 350;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 120;
   localparam int CYCLE_LIMIT    = 1_500_000;

   logic       clock;
   logic       reset                = 1'b1;
   logic       req_valid            = 1'b0;
   logic       req_stall;
   logic       req_command          = 1'b0;
   logic [5:0] req_ssid_length      = '0;
   logic [7:0] req_channel_number   = '0;
   logic [1:0] req_phy_flags        = '0;
   logic [4:0] req_akm_flags        = '0;
   logic [3:0] req_pairwise_ciphers = '0;
   logic [3:0] req_group_ciphers    = '0;
   logic [7:0] req_ssid_byte        = '0;
   logic       rsp_valid;
   logic       rsp_stall            = 1'b0;
   logic [7:0] rsp_first_byte;
   logic [7:0] rsp_second_byte;
   logic [1:0] rsp_byte_count;
   logic       rsp_last;

   int   mismatch_count;
   int   results_pending;
   int   cycle_count   = 0;
   int   burst_left    = 0;
   int   items_done    = 0;
   logic holdoff_armed = 1'b0;
   logic holdoff_done  = 1'b0;

   wlan_info_element_builder #(.SSID_MAX_BYTES(SSID_LIMIT)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_ssid_length      (req_ssid_length),
      .req_channel_number   (req_channel_number),
      .req_phy_flags        (req_phy_flags),
      .req_akm_flags        (req_akm_flags),
      .req_pairwise_ciphers (req_pairwise_ciphers),
      .req_group_ciphers    (req_group_ciphers),
      .req_ssid_byte        (req_ssid_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_first_byte       (rsp_first_byte),
      .rsp_second_byte      (rsp_second_byte),
      .rsp_byte_count       (rsp_byte_count),
      .rsp_last             (rsp_last)
   );

   wlan_info_element_builder_checker #(.SSID_MAX_BYTES(SSID_LIMIT)) element_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_ssid_length      (req_ssid_length),
      .req_channel_number   (req_channel_number),
      .req_phy_flags        (req_phy_flags),
      .req_akm_flags        (req_akm_flags),
      .req_pairwise_ciphers (req_pairwise_ciphers),
      .req_group_ciphers    (req_group_ciphers),
      .req_ssid_byte        (req_ssid_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_first_byte       (rsp_first_byte),
      .rsp_second_byte      (rsp_second_byte),
      .rsp_byte_count       (rsp_byte_count),
      .rsp_last             (rsp_last),
      .mismatch_count       (mismatch_count),
      .results_pending      (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wlan_info_element_builder verification failed");
         $finish;
      end
   end

   // Offer one item in bursts, idle between bursts, hold until accepted
   task automatic drive_item(input logic cmd, input logic [5:0] len, input logic [7:0] chan,
                             input logic [1:0] phy, input logic [4:0] akm,
                             input logic [3:0] pw, input logic [3:0] grp,
                             input logic [7:0] sbyte);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 10);
      end
      req_valid            <= 1'b1;
      req_command          <= cmd;
      req_ssid_length      <= len;
      req_channel_number   <= chan;
      req_phy_flags        <= phy;
      req_akm_flags        <= akm;
      req_pairwise_ciphers <= pw;
      req_group_ciphers    <= grp;
      req_ssid_byte        <= sbyte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_descriptor(input logic [5:0] len, input logic [7:0] chan,
                                  input logic [1:0] phy, input logic [4:0] akm,
                                  input logic [3:0] pw, input logic [3:0] grp);
      drive_item(CMD_DESCRIPTOR, len, chan, phy, akm, pw, grp, 8'($urandom_range(0, 255)));
   endtask

   // Fields other than the byte carry noise the block must ignore
   task automatic send_ssid_byte(input logic [7:0] sbyte);
      drive_item(CMD_SSID_BYTE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), sbyte);
   endtask

   // Receiver stalls: stretches of none, light, heavy or alternating, plus one long hold-off
   initial begin : receiver
      int mode;
      int stretch;
      int phase;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         stretch = $urandom_range(20, 120);
         repeat (stretch) begin
            @(posedge clock);
            if (holdoff_armed && !holdoff_done) begin
               rsp_stall <= 1'b1;
               repeat (HOLDOFF_CYCLES) @(posedge clock);
               holdoff_done = 1'b1;
            end else begin
               phase++;
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= phase[0];
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      int pick;
      int len;
      int eff;
      int nbytes;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Stray byte right after reset
      send_ssid_byte(8'h5a);
      // Empty SSID, no PHY flags, open network, all ciphers zero
      send_descriptor(6'd0, 8'd0, 2'd0, 5'h00, 4'h0, 4'h0);
      // WPA with EAP, all pairwise ciphers, group from pairwise, both rate sets
      send_descriptor(6'd0, 8'd255, 2'd3, 5'h09, 4'hf, 4'h0);
      // WPA with only GCMP pairwise: empty pairwise list
      send_descriptor(6'd0, 8'd1, 2'd1, 5'h01, 4'h4, 4'h8);
      // RSN with every AKM, short SSID at byte extremes
      send_descriptor(6'd2, 8'd6, 2'd2, 5'h1e, 4'hf, 4'hf);
      send_ssid_byte(8'h00);
      send_ssid_byte(8'hff);
      // SAE only: MFP required
      send_descriptor(6'd1, 8'd11, 2'd2, 5'h04, 4'h0, 4'h2);
      send_ssid_byte(8'ha5);
      // OWE, group taken from GCMP256 pairwise
      send_descriptor(6'd0, 8'd13, 2'd3, 5'h10, 4'h8, 4'h0);
      // PSK with TKIP pairwise and GCMP group
      send_descriptor(6'd0, 8'd14, 2'd1, 5'h02, 4'h2, 4'h4);
      // WPA1 wins over RSN bits
      send_descriptor(6'd0, 8'd7, 2'd0, 5'h1f, 4'h3, 4'h1);
      // Oversized SSID cut short, replaced by a new descriptor
      send_descriptor(6'd63, 8'd3, 2'd1, 5'h08, 4'h1, 4'h0);
      send_ssid_byte(8'h41);
      send_ssid_byte(8'h42);
      send_ssid_byte(8'h43);
      send_descriptor(6'd0, 8'd9, 2'd2, 5'h0a, 4'h5, 4'h0);
      // Stray byte after a finished network
      send_ssid_byte(8'h99);

      // Random networks, mostly well formed; one long receiver hold-off at the start
      holdoff_armed = 1'b1;
      while (items_done < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)      len = $urandom_range(0, 4);
         else if (pick < 85) len = $urandom_range(5, 12);
         else if (pick < 97) len = $urandom_range(13, 32);
         else                len = $urandom_range(33, 63);
         eff = (len > SSID_LIMIT) ? SSID_LIMIT : len;
         nbytes = eff;
         if (eff > 0 && $urandom_range(0, 9) == 0) nbytes = $urandom_range(0, eff - 1);
         send_descriptor(6'(len), 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                         5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)));
         repeat (nbytes) send_ssid_byte(8'($urandom_range(0, 255)));
         items_done += 1 + nbytes;
         if (nbytes == eff && $urandom_range(0, 7) == 0) send_ssid_byte(8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then let the block settle
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("wlan_info_element_builder verification clean");
      end else begin
         $display("wlan_info_element_builder verification failed");
      end
      $finish;
   end

endmodule
